// ----- design/bchf_pkg.sv -----
// Package for the binned cut histogram fill block.
// Holds the request and result types, the binning tables and the fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package bchf_pkg;

    // Request modes.
    localparam logic MODE_FILL = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAPIDITY_LIMIT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_STEP  = 2'd2;

    localparam logic [14:0]        RAPIDITY_LIMIT_RST  = 15'd4096;
    localparam logic signed [15:0] FIRST_THRESHOLD_RST = -16'sd600;
    localparam logic [9:0]         THRESHOLD_STEP_RST  = 10'd50;

    // Momentum bin edges in 1/256 GeV: 1, 2, 3, 4, 5, 6, 8, 10, 15, 20 GeV.
    localparam int PT_EDGE_COUNT = 10;
    localparam int PT_BIN_COUNT  = PT_EDGE_COUNT - 1;
    localparam int PT_BIN_W      = 4;
    localparam logic [15:0] PT_EDGES [PT_EDGE_COUNT] = '{
        16'd256, 16'd512, 16'd768, 16'd1024, 16'd1280,
        16'd1536, 16'd2048, 16'd2560, 16'd3840, 16'd5120
    };

    // Centrality bin edges in half-percent steps.
    localparam int CENT_EDGE_COUNT = 5;
    localparam int CENT_BIN_COUNT  = CENT_EDGE_COUNT - 1;
    localparam int CENT_BIN_W      = 2;
    localparam logic [7:0] CENT_EDGES [CENT_EDGE_COUNT] = '{
        8'd0, 8'd20, 8'd60, 8'd100, 8'd180
    };

    // Mass binning in 0.1 MeV: 5 MeV bins starting at 1.74 GeV.
    localparam int MASS_LOW  = 17400;
    localparam int MASS_STEP = 50;
    // floor(d / 50) equals (d * 20972) >> 20 exactly for every d below 43690,
    // which covers the largest regular mass span.
    localparam int MASS_RECIP   = 20972;
    localparam int MASS_RECIP_W = 15;
    localparam int MASS_SHIFT   = 20;

    typedef struct packed {
        logic               mode;
        logic [15:0]        momentum;
        logic [15:0]        cand_mass;
        logic signed [15:0] rapidity;
        logic signed [15:0] score;
        logic [7:0]         centrality_class;
        logic [3:0]         read_momentum_bin;
        logic [1:0]         read_centrality_bin;
        logic [4:0]         read_threshold;
        logic [5:0]         read_mass_bin;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  momentum_bin;
        logic [1:0]  centrality_bin;
        logic [5:0]  mass_bin;
        logic [4:0]  thresholds_passed;
        logic [31:0] bin_count;
    } result_t;

endpackage

// ----- design/bchf_if.sv -----
// Request and result channel interfaces of the binned cut histogram fill block.
// Depends on bchf_pkg for the payload types.
`timescale 1ns / 1ps

interface bchf_item_if;
    logic            valid;
    logic            ready;
    bchf_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bchf_result_if;
    logic              valid;
    logic              ready;
    bchf_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/binned_cut_histogram_fill.sv -----
// Cut-based mass histogram accumulator with all counters in one synchronous memory.
// Depends on bchf_pkg and the channel interfaces in bchf_if.
// An accepted fill request goes through S_DECODE and S_ADDR to S_FILL, which does one
// read-modify-write of the counter memory per cycle, one per threshold passed.
// Rejects skip S_FILL; reads use S_READ and S_RDWAIT. One request is in work at a time;
// a result waiting in the output register does not hold off the next request.
// After reset the counter memory is cleared one entry per cycle (DEPTH, 48600 by default)
// with no request taken; configuration writes are taken throughout.
`timescale 1ns / 1ps

module binned_cut_histogram_fill #(
    parameter int NUM_THRESHOLDS      = 25,
    parameter int NUM_MASS_BINS       = 52,
    parameter int NUM_MOMENTUM_BINS   = 9,
    parameter int NUM_CENTRALITY_BINS = 4,
    parameter int COUNT_WIDTH         = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bchf_item_if.sink                         item,
    bchf_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [bchf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bchf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int MASS_SLOTS = NUM_MASS_BINS + 2;
    localparam int DEPTH      = NUM_MOMENTUM_BINS * NUM_CENTRALITY_BINS *
                                NUM_THRESHOLDS * MASS_SLOTS;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MB_W       = $clog2(MASS_SLOTS);
    localparam int MSEL_W     = (MB_W > 6) ? MB_W : 6;
    localparam int T_W        = $clog2(NUM_THRESHOLDS + 1);
    localparam int PROD_TW    = 10 + ((NUM_THRESHOLDS > 1) ? $clog2(NUM_THRESHOLDS) : 1);
    localparam int THR_W      = ((PROD_TW + 1 > 16) ? PROD_TW + 1 : 16) + 1;
    localparam int MASS_TOP   = bchf_pkg::MASS_LOW + bchf_pkg::MASS_STEP * NUM_MASS_BINS;
    localparam int DIFF_W     = $clog2(bchf_pkg::MASS_STEP * NUM_MASS_BINS);
    localparam int PROD_W     = DIFF_W + bchf_pkg::MASS_RECIP_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ADDR,
        S_FILL,
        S_READ,
        S_RDWAIT,
        S_DONE
    } state_t;

    state_t                      state_reg;
    logic [AW-1:0]               clr_addr_reg;
    bchf_pkg::item_t             item_reg;
    logic                        hit_reg;
    logic [bchf_pkg::PT_BIN_W-1:0]   p_reg;
    logic [bchf_pkg::CENT_BIN_W-1:0] c_reg;
    logic [4:0]                  th_reg;
    logic [MSEL_W-1:0]           m_reg;
    logic [AW-1:0]               addr_reg;
    logic signed [THR_W-1:0]     thr_reg;
    logic [T_W-1:0]              t_reg;
    logic [31:0]                 count_reg;
    logic                        wr_pend_reg;
    logic [AW-1:0]               wr_addr_reg;
    logic                        out_valid_reg;
    bchf_pkg::result_t           result_reg;

    logic [14:0]                 rapidity_limit_reg;
    logic signed [15:0]          first_thr_reg;
    logic [9:0]                  step_reg;

    logic [COUNT_WIDTH-1:0]      mem [DEPTH];
    logic [COUNT_WIDTH-1:0]      mem_rdata_reg;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [COUNT_WIDTH-1:0]      mem_wdata;
    logic                        mem_re;

    logic                        dec_hit;
    logic [bchf_pkg::PT_BIN_W-1:0]   dec_p;
    logic [bchf_pkg::CENT_BIN_W-1:0] dec_c;
    logic [4:0]                  dec_th;
    logic [MSEL_W-1:0]           dec_m;
    logic                        p_found;
    logic                        c_found;
    logic [15:0]                 abs_rap;
    logic [DIFF_W-1:0]           mass_diff;
    logic [PROD_W-1:0]           mass_prod;
    logic [AW-1:0]               addr_calc;
    logic                        fill_go;
    logic [COUNT_WIDTH-1:0]      sat_inc;
    bchf_pkg::result_t           res_calc;

    assign item.ready   = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = result_reg;

    // Request decode: cuts and bins for a fill, range check for a read.
    always_comb
    begin
        p_found   = 1'b0;
        c_found   = 1'b0;
        dec_p     = '0;
        dec_c     = '0;
        abs_rap   = item_reg.rapidity[15] ? 16'(-item_reg.rapidity) : 16'(item_reg.rapidity);
        mass_diff = DIFF_W'(32'(item_reg.cand_mass) - bchf_pkg::MASS_LOW);
        mass_prod = PROD_W'(mass_diff) * PROD_W'(bchf_pkg::MASS_RECIP);
        for (int k = 0; k < bchf_pkg::PT_BIN_COUNT; k++)
        begin
            if (k < NUM_MOMENTUM_BINS &&
                item_reg.momentum >= bchf_pkg::PT_EDGES[k] &&
                item_reg.momentum <  bchf_pkg::PT_EDGES[k+1])
            begin
                p_found = 1'b1;
                dec_p   = bchf_pkg::PT_BIN_W'(k);
            end
        end
        for (int k = 0; k < bchf_pkg::CENT_BIN_COUNT; k++)
        begin
            if (k < NUM_CENTRALITY_BINS &&
                item_reg.centrality_class >= bchf_pkg::CENT_EDGES[k] &&
                item_reg.centrality_class <  bchf_pkg::CENT_EDGES[k+1])
            begin
                c_found = 1'b1;
                dec_c   = bchf_pkg::CENT_BIN_W'(k);
            end
        end
        if (32'(item_reg.cand_mass) < bchf_pkg::MASS_LOW)
        begin
            dec_m = '0;
        end
        else if (32'(item_reg.cand_mass) >= MASS_TOP)
        begin
            dec_m = MSEL_W'(NUM_MASS_BINS + 1);
        end
        else
        begin
            dec_m = MSEL_W'(mass_prod >> bchf_pkg::MASS_SHIFT) + MSEL_W'(1);
        end
        dec_th  = '0;
        dec_hit = (32'(abs_rap) < 32'(rapidity_limit_reg)) && p_found && c_found;
        if (item_reg.mode == bchf_pkg::MODE_READ)
        begin
            dec_p   = item_reg.read_momentum_bin;
            dec_c   = item_reg.read_centrality_bin;
            dec_th  = item_reg.read_threshold;
            dec_m   = MSEL_W'(item_reg.read_mass_bin);
            dec_hit = (32'(item_reg.read_momentum_bin) < NUM_MOMENTUM_BINS) &&
                      (32'(item_reg.read_centrality_bin) < NUM_CENTRALITY_BINS) &&
                      (32'(item_reg.read_threshold) < NUM_THRESHOLDS) &&
                      (32'(item_reg.read_mass_bin) < MASS_SLOTS);
        end
    end

    assign addr_calc = AW'(((int'(p_reg) * NUM_CENTRALITY_BINS + int'(c_reg)) *
                            NUM_THRESHOLDS + int'(th_reg)) * MASS_SLOTS + int'(m_reg));

    // Thresholds do not fall as the index rises, so the first one not exceeded ends the fill.
    assign fill_go = (state_reg == S_FILL) && (32'(t_reg) < NUM_THRESHOLDS) &&
                     (THR_W'(item_reg.score) > thr_reg);

    assign sat_inc   = (mem_rdata_reg == '1) ? mem_rdata_reg
                                             : mem_rdata_reg + COUNT_WIDTH'(1);
    assign mem_re    = fill_go || (state_reg == S_READ);
    assign mem_we    = (state_reg == S_CLEAR) || wr_pend_reg;
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : wr_addr_reg;
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : sat_inc;

    always_comb
    begin
        res_calc = '0;
        if (item_reg.mode == bchf_pkg::MODE_READ)
        begin
            res_calc.bin_count = count_reg;
        end
        else if (hit_reg)
        begin
            res_calc.accepted          = 1'b1;
            res_calc.momentum_bin      = p_reg;
            res_calc.centrality_bin    = c_reg;
            res_calc.mass_bin          = 6'(m_reg);
            res_calc.thresholds_passed = 5'(t_reg);
        end
    end

    // Counter memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_CLEAR;
            clr_addr_reg       <= '0;
            item_reg           <= '0;
            hit_reg            <= 1'b0;
            p_reg              <= '0;
            c_reg              <= '0;
            th_reg             <= '0;
            m_reg              <= '0;
            addr_reg           <= '0;
            thr_reg            <= '0;
            t_reg              <= '0;
            count_reg          <= '0;
            wr_pend_reg        <= 1'b0;
            wr_addr_reg        <= '0;
            out_valid_reg      <= 1'b0;
            result_reg         <= '0;
            rapidity_limit_reg <= bchf_pkg::RAPIDITY_LIMIT_RST;
            first_thr_reg      <= bchf_pkg::FIRST_THRESHOLD_RST;
            step_reg           <= bchf_pkg::THRESHOLD_STEP_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bchf_pkg::CFG_RAPIDITY_LIMIT:  rapidity_limit_reg <= cfg_data[14:0];
                    bchf_pkg::CFG_FIRST_THRESHOLD: first_thr_reg      <= $signed(cfg_data);
                    bchf_pkg::CFG_THRESHOLD_STEP:  step_reg           <= cfg_data[9:0];
                    default: ;
                endcase
            end

            // In S_DONE the output register is either kept or reloaded below.
            if (out_valid_reg && result.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            // Write-back stage of the read-modify-write.
            wr_pend_reg <= fill_go;
            wr_addr_reg <= addr_reg;

            unique case (state_reg)
                S_CLEAR:
                begin
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + AW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        item_reg  <= item.data;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    hit_reg   <= dec_hit;
                    p_reg     <= dec_p;
                    c_reg     <= dec_c;
                    th_reg    <= dec_th;
                    m_reg     <= dec_m;
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    addr_reg  <= addr_calc;
                    thr_reg   <= THR_W'(first_thr_reg);
                    t_reg     <= '0;
                    count_reg <= '0;
                    if (!hit_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (item_reg.mode == bchf_pkg::MODE_READ)
                    begin
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_FILL;
                    end
                end
                S_FILL:
                begin
                    if (fill_go)
                    begin
                        addr_reg <= addr_reg + AW'(MASS_SLOTS);
                        thr_reg  <= thr_reg + THR_W'($signed({1'b0, step_reg}));
                        t_reg    <= t_reg + T_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_RDWAIT;
                end
                S_RDWAIT:
                begin
                    count_reg <= 32'(mem_rdata_reg);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        result_reg    <= res_calc;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // The write-back never lands on the entry being read in the same cycle.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_pend_reg && mem_re) |-> (wr_addr_reg != addr_reg))
        else $error("counter write and read hit the same entry");

    // Every write-back follows a fill read in the previous cycle.
    a_wb_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> $past(fill_go))
        else $error("counter write-back without a matching read");

    // No read-modify-write is still in flight when a new request can enter.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_pend_reg)
        else $error("write-back pending while idle");

    // The fill never steps past the last threshold.
    a_thr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (32'(t_reg) <= NUM_THRESHOLDS))
        else $error("threshold index out of range");
`endif

endmodule
